// ----- rtl/slcd_pkg.sv -----
// ----------------------------------------------------------------------------
// slcd_pkg - segment LCD number composer package
// Command codes, glyph table, word layout and the digit placement function.
// ----------------------------------------------------------------------------
package slcd_pkg;

    localparam int VALUE_W   = 14;
    localparam int DIGITS    = 4;
    localparam int BCD_W     = 4 * DIGITS;
    localparam int CODE_W    = 16;

    localparam logic [VALUE_W-1:0] OVER_RANGE_LIMIT = VALUE_W'(9999);
    localparam logic [VALUE_W-1:0] MEMORY_LIMIT     = VALUE_W'(99);
    localparam logic [31:0]        POINT_BIT        = 32'h0008_0000;
    localparam logic [31:0]        MEM_MASK_ZERO    = 32'hffff_f80f;
    localparam logic [31:0]        MEM_MASK_ONE     = 32'hffff_ff80;

    localparam logic [3:0] GLYPH_BLANK = 4'd11;
    localparam logic [3:0] GLYPH_LOW_R = 4'd12;
    localparam logic [3:0] GLYPH_E     = 4'd13;

    typedef enum logic [1:0] {
        CMD_NUMBER = 2'd0,
        CMD_MEMORY = 2'd1,
        CMD_ERROR  = 2'd2,
        CMD_CLEAR  = 2'd3
    } command_t;

    typedef struct packed {
        logic [31:0] word_zero;
        logic [31:0] word_one;
        logic [31:0] word_two;
        logic [31:0] word_three;
    } words_t;

    // segment codes; indices 14 and 15 show nothing
    function automatic logic [CODE_W-1:0] glyph(input logic [3:0] idx);
        logic [CODE_W-1:0] code;
        case (idx)
            4'd0:    code = 16'h050F;
            4'd1:    code = 16'h0006;
            4'd2:    code = 16'h060B;
            4'd3:    code = 16'h020F;
            4'd4:    code = 16'h0306;
            4'd5:    code = 16'h030D;
            4'd6:    code = 16'h070D;
            4'd7:    code = 16'h0007;
            4'd8:    code = 16'h070F;
            4'd9:    code = 16'h030F;
            4'd10:   code = 16'h0008;
            4'd11:   code = 16'h0000;
            4'd12:   code = 16'h0709;
            4'd13:   code = 16'h0707;
            default: code = 16'h0000;
        endcase
        return code;
    endfunction

    // low and high bytes of each code land in different words, but c2 lands whole in word_two
    function automatic words_t place_digits(input logic [CODE_W-1:0] c0,
                                            input logic [CODE_W-1:0] c1,
                                            input logic [CODE_W-1:0] c2,
                                            input logic [CODE_W-1:0] c3);
        words_t w;
        w.word_zero  = {c0[7:0], 24'h0};
        w.word_one   = {c1[7:0], c0[15:8], 16'h0};
        w.word_two   = {c3[7:0], c2, c1[15:8]};
        w.word_three = {8'h0, c3[15:8], 16'h0};
        return w;
    endfunction

endpackage

// ----- rtl/slcd_if.sv -----
// ----------------------------------------------------------------------------
// slcd_if - stream interfaces of the segment LCD number composer
// Command channel in, display word channel out; valid/ready handshake.
// ----------------------------------------------------------------------------
interface slcd_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [13:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

interface slcd_word_if;
    logic        valid;
    logic        ready;
    logic [31:0] word_zero;
    logic [31:0] word_one;
    logic [31:0] word_two;
    logic [31:0] word_three;

    modport source (output valid, output word_zero, output word_one,
                    output word_two, output word_three, input ready);
    modport sink   (input valid, input word_zero, input word_one,
                    input word_two, input word_three, output ready);
endinterface

// ----- rtl/slcd_bin2bcd.sv -----
// ----------------------------------------------------------------------------
// slcd_bin2bcd - bit-serial binary to BCD converter
// Shift-and-add-3: one binary bit enters the BCD shift register per cycle.
// ----------------------------------------------------------------------------
module slcd_bin2bcd
    import slcd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [VALUE_W-1:0] value,
    output logic               done,
    output logic [BCD_W-1:0]   bcd
);

    localparam int CNT_W = $clog2(VALUE_W);
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(VALUE_W - 1);

    logic [VALUE_W-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               run_reg, run_next;
    logic               done_reg, done_next;
    logic [BCD_W-1:0]   adjusted;

    // digits of five or more get three added before the shift
    always_comb
    begin
        for (int k = 0; k < DIGITS; k++)
        begin
            if (bcd_reg[4*k +: 4] >= 4'd5)
                adjusted[4*k +: 4] = bcd_reg[4*k +: 4] + 4'd3;
            else
                adjusted[4*k +: 4] = bcd_reg[4*k +: 4];
        end
    end

    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            bin_next = value;
            bcd_next = '0;
            cnt_next = LAST_BIT;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            bcd_next = {adjusted[BCD_W-2:0], bin_reg[VALUE_W-1]};
            bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            else
                cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

// ----- rtl/segment_lcd_number_composer.sv -----
// ----------------------------------------------------------------------------
// segment_lcd_number_composer - four-word segment LCD composer
// Turns number, memory, error and clear commands into LCD RAM words and
// keeps a shadow copy of the last words composed; clear outputs zero words and leaves the shadow copy as it is.
//
//   channel | dir | words carried
//   --------+-----+-----------------------------------------------
//   cmd     | in  | command, value
//   words   | out | word_zero, word_one, word_two, word_three
//
// Number and memory commands run through the 14-step bit-serial BCD
// conversion before the output word is loaded; error and clear do not.
// A new command is taken once the previous one has been loaded into the
// output register; a stalled output holds the block in its final state.
// Reset clears the shadow copy to zero and empties the output register.
// ----------------------------------------------------------------------------
module segment_lcd_number_composer
    import slcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    slcd_cmd_if.sink    cmd,
    slcd_word_if.source words
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CONV = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    command_t           cmd_reg;
    logic [VALUE_W-1:0] val_reg;
    words_t             shadow_reg, shadow_next;
    words_t             out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    logic               accept;
    logic               load;
    logic               conv_done;
    logic [BCD_W-1:0]   bcd;

    assign accept = cmd.valid && cmd.ready;
    assign load   = (state_reg == S_DONE) && (!out_valid_reg || words.ready);

    slcd_bin2bcd u_bin2bcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept && (cmd.command == CMD_NUMBER || cmd.command == CMD_MEMORY)),
        .value (cmd.value),
        .done  (conv_done),
        .bcd   (bcd)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (accept)
                begin
                    if (cmd.command == CMD_NUMBER || cmd.command == CMD_MEMORY)
                        state_next = S_CONV;
                    else
                        state_next = S_DONE;
                end
            S_CONV:
                if (conv_done)
                    state_next = S_DONE;
            S_DONE:
                if (load)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // word composition
    always_comb
    begin
        logic [3:0]        d0, d1, d2, d3;
        words_t            placed;
        logic [CODE_W-1:0] g_units, g_tens;
        d0 = bcd[3:0];
        d1 = bcd[7:4];
        d2 = bcd[11:8];
        d3 = bcd[15:12];
        g_units = glyph(bcd[3:0]);
        g_tens  = glyph(bcd[7:4]);
        placed  = '0;
        shadow_next = shadow_reg;
        out_next    = shadow_reg;
        case (cmd_reg)
            CMD_NUMBER:
            begin
                if (val_reg > OVER_RANGE_LIMIT)
                begin
                    d0 = GLYPH_BLANK;
                    d1 = GLYPH_E;
                    d2 = GLYPH_E;
                    d3 = GLYPH_LOW_R;
                end
                else if (d3 == 4'd0)
                begin
                    // leading zeros blanked in the top two places only
                    d3 = GLYPH_BLANK;
                    if (d2 == 4'd0)
                        d2 = GLYPH_BLANK;
                end
                placed = place_digits(glyph(d0), glyph(d1), glyph(d2), glyph(d3));
                placed.word_one = placed.word_one | POINT_BIT;
                shadow_next = placed;
                out_next    = placed;
            end
            CMD_MEMORY:
            begin
                if (val_reg <= MEMORY_LIMIT)
                begin
                    shadow_next.word_zero = (shadow_reg.word_zero & MEM_MASK_ZERO)
                                          | {8'h0, g_units, 8'h0};
                    shadow_next.word_one  = (shadow_reg.word_one & MEM_MASK_ONE)
                                          | {16'h0, g_tens};
                end
                out_next = shadow_next;
            end
            CMD_ERROR:
            begin
                placed = place_digits(glyph(GLYPH_E), glyph(GLYPH_E),
                                      glyph(GLYPH_LOW_R), glyph(GLYPH_BLANK));
                shadow_next = placed;
                out_next    = placed;
            end
            CMD_CLEAR:
                out_next = '0;
            default:
                out_next = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (words.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            shadow_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (load)
                shadow_reg <= shadow_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= command_t'(cmd.command);
            val_reg <= cmd.value;
        end
        if (load)
            out_reg <= out_next;
    end

    assign cmd.ready        = (state_reg == S_IDLE);
    assign words.valid      = out_valid_reg;
    assign words.word_zero  = out_reg.word_zero;
    assign words.word_one   = out_reg.word_one;
    assign words.word_two   = out_reg.word_two;
    assign words.word_three = out_reg.word_three;

endmodule

// ----- rtl/slcd_checker.sv -----
// ----------------------------------------------------------------------------
// slcd_checker - port-level checks for the segment LCD number composer
// Bound to the top level; watches the command and word channels.
// ----------------------------------------------------------------------------
module slcd_checker
    import slcd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        cmd_valid,
    input logic        cmd_ready,
    input logic [1:0]  cmd_command,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_zero,
    input logic [31:0] out_one,
    input logic [31:0] out_two,
    input logic [31:0] out_three
);

    localparam words_t ERROR_WORDS = place_digits(glyph(GLYPH_E), glyph(GLYPH_E),
                                                  glyph(GLYPH_LOW_R), glyph(GLYPH_BLANK));

    logic cmd_take;
    assign cmd_take = cmd_valid && cmd_ready;

    // stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_zero) && $stable(out_one)
                                    && $stable(out_two) && $stable(out_three))
        else $error("output word changed under stall");

    // one command in flight at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |=> !cmd_ready)
        else $error("command taken while busy");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take && cmd_command == CMD_CLEAR && !out_valid |-> ##2
        (out_valid && out_zero == '0 && out_one == '0 && out_two == '0 && out_three == '0))
        else $error("clear did not give zero words");

    a_error: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take && cmd_command == CMD_ERROR && !out_valid |-> ##2
        (out_valid && out_zero == ERROR_WORDS.word_zero && out_one == ERROR_WORDS.word_one
         && out_two == ERROR_WORDS.word_two && out_three == ERROR_WORDS.word_three))
        else $error("error pattern wrong");

endmodule

bind segment_lcd_number_composer slcd_checker u_slcd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd.valid),
    .cmd_ready   (cmd.ready),
    .cmd_command (cmd.command),
    .out_valid   (words.valid),
    .out_ready   (words.ready),
    .out_zero    (words.word_zero),
    .out_one     (words.word_one),
    .out_two     (words.word_two),
    .out_three   (words.word_three)
);
